@@ src/psev_pkg.sv @@
// Package for the postfix stack evaluator: widths, token and status codes,
// and the command/status structs between controller and datapath. No dependencies.
`timescale 1ns / 1ps
package psev_pkg;

  localparam int STACK_DEPTH = 128;
  localparam int ADDR_W      = $clog2(STACK_DEPTH);
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int DATA_W      = 32;
  localparam int OP_W        = 3;
  localparam int DEPTH_W     = 8;

  // Token kinds; codes above TOK_DIV are ignored tokens
  localparam logic [OP_W-1:0] TOK_OPERAND = 3'd0;
  localparam logic [OP_W-1:0] TOK_ADD     = 3'd1;
  localparam logic [OP_W-1:0] TOK_SUB     = 3'd2;
  localparam logic [OP_W-1:0] TOK_MUL     = 3'd3;
  localparam logic [OP_W-1:0] TOK_DIV     = 3'd4;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_UNDER = 2'd1,
    ST_FULL  = 2'd2,
    ST_DIVZ  = 2'd3
  } status_e;

  // Controller to datapath
  typedef struct packed {
    logic accept;
    logic push_in;
    logic pop;
    logic load_r;
    logic load_l;
    logic exec;
    logic div_start;
    logic load_quo;
    logic push_res;
    logic emit;
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic empty;
    logic full;
    logic right_zero;
    logic div_done;
    logic out_free;
  } dp_stat_t;

endpackage

@@ src/psev_if.sv @@
// Valid/ready channel interfaces for the token input and the result output.
// Depends on psev_pkg for field widths.
`timescale 1ns / 1ps
interface psev_in_if;
  import psev_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [OP_W-1:0]          op;
  logic signed [DATA_W-1:0] value;
  logic                     last;

  modport source (output valid, output op, output value, output last, input ready);
  modport sink   (input valid, input op, input value, input last, output ready);
endinterface

interface psev_out_if;
  import psev_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] result;
  logic [1:0]               status;
  logic [DEPTH_W-1:0]       depth;
  logic                     done_res;

  modport source (output valid, output result, output status, output depth,
                  output done_res, input ready);
  modport sink   (input valid, input result, input status, input depth,
                  input done_res, output ready);
endinterface

@@ src/psev_div.sv @@
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
// Depends on psev_pkg.
`timescale 1ns / 1ps
module psev_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [psev_pkg::DATA_W-1:0]  dividend_i,
  input  logic [psev_pkg::DATA_W-1:0]  divisor_i,
  output logic                         done_o,
  output logic [psev_pkg::DATA_W-1:0]  quotient_o
);
  import psev_pkg::*;

  localparam int STEP_W = $clog2(DATA_W);

  logic              busy_q, done_q, neg_q;
  logic [STEP_W-1:0] step_q;
  logic [DATA_W:0]   rem_q;
  logic [DATA_W-1:0] quo_q, dvs_q;
  logic [DATA_W:0]   shifted, diff;
  logic [DATA_W-1:0] mag_a, mag_b;

  // Operand magnitudes; the most negative value maps to its unsigned magnitude
  assign mag_a = dividend_i[DATA_W-1] ? (~dividend_i + 1'b1) : dividend_i;
  assign mag_b = divisor_i[DATA_W-1]  ? (~divisor_i + 1'b1)  : divisor_i;

  // Restoring step: shift in the next dividend bit, try to subtract
  assign shifted = {rem_q[DATA_W-1:0], quo_q[DATA_W-1]};
  assign diff    = shifted - {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        step_q <= step_q + 1'b1;
        if (step_q == STEP_W'(DATA_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Hold the working remainder and quotient
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= mag_a;
      dvs_q <= mag_b;
      neg_q <= dividend_i[DATA_W-1] ^ divisor_i[DATA_W-1];
    end else if (busy_q) begin
      if (!diff[DATA_W]) begin
        rem_q <= diff;
        quo_q <= {quo_q[DATA_W-2:0], 1'b1};
      end else begin
        rem_q <= shifted;
        quo_q <= {quo_q[DATA_W-2:0], 1'b0};
      end
    end
  end

  assign done_o     = done_q;
  assign quotient_o = neg_q ? (~quo_q + 1'b1) : quo_q;

endmodule

@@ src/psev_dp.sv @@
// Datapath: stack memory and count, operand registers, ALU, divider and
// output register. Depends on psev_pkg and psev_div.
`timescale 1ns / 1ps
module psev_dp (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  psev_pkg::ctrl_cmd_t               cmd_i,
  output psev_pkg::dp_stat_t                stat_o,
  input  logic [psev_pkg::OP_W-1:0]         in_op_i,
  input  logic [psev_pkg::DATA_W-1:0]       in_value_i,
  input  logic                              in_last_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [psev_pkg::DATA_W-1:0]       out_result_o,
  output logic [1:0]                        out_status_o,
  output logic [psev_pkg::DEPTH_W-1:0]      out_depth_o,
  output logic                              out_done_o
);
  import psev_pkg::*;

  logic [DATA_W-1:0] mem [STACK_DEPTH];
  logic [CNT_W-1:0]  count_q, count_dec;
  logic [ADDR_W-1:0] wr_addr, rd_addr;
  logic [DATA_W-1:0] rd_q, right_q, left_q, res_q, last_res_q, wr_data, quo;
  logic              pop_empty_q, last_q, empty, full, wr_en, rd_en, div_done;
  logic [OP_W-1:0]   tok_q;
  status_e           status_q;
  logic              out_valid_q, out_done_q;
  logic [DATA_W-1:0] out_result_q;
  status_e           out_status_q;
  logic [DEPTH_W-1:0] out_depth_q;

  assign empty     = (count_q == '0);
  assign full      = (count_q >= CNT_W'(STACK_DEPTH));
  assign count_dec = count_q - 1'b1;
  assign wr_addr   = count_q[ADDR_W-1:0];
  assign rd_addr   = count_dec[ADDR_W-1:0];
  assign wr_en     = (cmd_i.push_in || cmd_i.push_res) && !full;
  assign rd_en     = cmd_i.pop && !empty;
  assign wr_data   = cmd_i.push_in ? in_value_i : res_q;

  // Stack memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  psev_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (left_q),
    .divisor_i  (right_q),
    .done_o     (div_done),
    .quotient_o (quo)
  );

  // Control state: stack count, latest result and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      last_res_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.emit && last_q) begin
        count_q <= '0;
      end else if (wr_en) begin
        count_q <= count_q + 1'b1;
      end else if (rd_en) begin
        count_q <= count_dec;
      end
      if (cmd_i.emit && last_q) begin
        last_res_q <= '0;
      end else if (cmd_i.push_res) begin
        last_res_q <= res_q;
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Item payload, operands, result and output register
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      tok_q    <= in_op_i;
      last_q   <= in_last_i;
      status_q <= (cmd_i.push_in && full) ? ST_FULL : ST_OK;
    end
    if (cmd_i.pop) begin
      pop_empty_q <= empty;
      if (empty) begin
        status_q <= ST_UNDER;
      end
    end
    if (cmd_i.load_r) begin
      right_q <= pop_empty_q ? '1 : rd_q;
    end
    if (cmd_i.load_l) begin
      left_q <= pop_empty_q ? '1 : rd_q;
    end
    if (cmd_i.exec) begin
      unique case (tok_q)
        TOK_ADD: res_q <= left_q + right_q;
        TOK_SUB: res_q <= left_q - right_q;
        TOK_MUL: res_q <= left_q * right_q;
        TOK_DIV: begin
          if (right_q == '0) begin
            res_q    <= '0;
            status_q <= ST_DIVZ;
          end
        end
        default: res_q <= res_q;
      endcase
    end
    if (cmd_i.load_quo) begin
      res_q <= quo;
    end
    if (cmd_i.push_res && full) begin
      status_q <= ST_FULL;
    end
    if (cmd_i.emit) begin
      out_result_q <= last_res_q;
      out_status_q <= status_q;
      out_depth_q  <= DEPTH_W'(count_q);
      out_done_q   <= last_q;
    end
  end

  assign stat_o.empty      = empty;
  assign stat_o.full       = full;
  assign stat_o.right_zero = (right_q == '0);
  assign stat_o.div_done   = div_done;
  assign stat_o.out_free   = !out_valid_q || out_ready_i;

  assign out_valid_o  = out_valid_q;
  assign out_result_o = out_result_q;
  assign out_status_o = out_status_q;
  assign out_depth_o  = out_depth_q;
  assign out_done_o   = out_done_q;

endmodule

@@ src/psev_ctrl.sv @@
// Controller: sequences accept, pops, operate, push and output for an operator item;
// other items go from accept to output. Depends on psev_pkg.
`timescale 1ns / 1ps
module psev_ctrl (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  input  logic [psev_pkg::OP_W-1:0] in_op_i,
  output logic                      in_ready_o,
  input  psev_pkg::dp_stat_t        stat_i,
  output psev_pkg::ctrl_cmd_t       cmd_o
);
  import psev_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_POP_R, S_POP_L, S_LOAD_L, S_EXEC, S_DIV_WAIT, S_PUSH, S_EMIT
  } state_e;

  state_e          state_q;
  logic [OP_W-1:0] tok_q;
  logic            is_oper;

  assign is_oper = (in_op_i != TOK_OPERAND) && (in_op_i <= TOK_DIV);

  // Hold state and the token kind of the item at work
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      tok_q   <= TOK_OPERAND;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            tok_q   <= in_op_i;
            state_q <= is_oper ? S_POP_R : S_EMIT;
          end
        end
        S_POP_R:  state_q <= S_POP_L;
        S_POP_L:  state_q <= S_LOAD_L;
        S_LOAD_L: state_q <= S_EXEC;
        S_EXEC: begin
          state_q <= (tok_q == TOK_DIV && !stat_i.right_zero) ? S_DIV_WAIT : S_PUSH;
        end
        S_DIV_WAIT: begin
          if (stat_i.div_done) begin
            state_q <= S_PUSH;
          end
        end
        S_PUSH: state_q <= S_EMIT;
        S_EMIT: begin
          if (stat_i.out_free) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // Decode datapath commands from state
  always_comb begin
    cmd_o           = '0;
    cmd_o.accept    = (state_q == S_IDLE) && in_valid_i;
    cmd_o.push_in   = cmd_o.accept && (in_op_i == TOK_OPERAND);
    cmd_o.pop       = (state_q == S_POP_R) || (state_q == S_POP_L);
    cmd_o.load_r    = (state_q == S_POP_L);
    cmd_o.load_l    = (state_q == S_LOAD_L);
    cmd_o.exec      = (state_q == S_EXEC);
    cmd_o.div_start = (state_q == S_EXEC) && (tok_q == TOK_DIV) && !stat_i.right_zero;
    cmd_o.load_quo  = (state_q == S_DIV_WAIT) && stat_i.div_done;
    cmd_o.push_res  = (state_q == S_PUSH);
    cmd_o.emit      = (state_q == S_EMIT) && stat_i.out_free;
  end

  assign in_ready_o = (state_q == S_IDLE);

endmodule

@@ src/postfix_stack_evaluator.sv @@
// Postfix evaluator on a 32-bit integer stack: controller, datapath, divider.
// An operand or ignored token goes from accept straight to the emit state; an operator
// steps through pop right, pop left, load left, execute, push and emit, with a wait on
// the 32-step divider after execute for a divide by a nonzero value. A new item is accepted
// only once the last result is registered; a result still held by the sink delays the emit.
// Reset clears the controller, stack count and latest result; the stack
// memory is not cleared, entries are read only below the count.
`timescale 1ns / 1ps
module postfix_stack_evaluator (
  input  logic          clk_i,
  input  logic          rst_ni,
  psev_in_if.sink       in_i,
  psev_out_if.source    out_o
);
  import psev_pkg::*;

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  psev_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_op_i    (in_i.op),
    .in_ready_o (in_i.ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  psev_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .in_op_i      (in_i.op),
    .in_value_i   (in_i.value),
    .in_last_i    (in_i.last),
    .out_valid_o  (out_o.valid),
    .out_ready_i  (out_o.ready),
    .out_result_o (out_o.result),
    .out_status_o (out_o.status),
    .out_depth_o  (out_o.depth),
    .out_done_o   (out_o.done_res)
  );

  // An accepted operator starts popping in the next cycle
  a_oper_pops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.accept && in_i.op != TOK_OPERAND && in_i.op <= TOK_DIV) |=> cmd.pop)
    else $error("operator item did not start popping");

  // The divider never reports done in the cycle after a start
  a_div_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.div_start |=> !stat.div_done)
    else $error("divider finished too early");

  // The stack cannot be empty and full at once
  a_empty_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(stat.empty && stat.full))
    else $error("stack count inconsistent");

endmodule
